// ===== rtl/core/ncde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncde_pkg
// Shared types, codes and constants of the 3x3 color-difference edge core.
// ----------------------------------------------------------------------------
package ncde_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEFAULT    = 1024;
   localparam int CHANNEL_BITS_DEFAULT = 16;

   // Frame geometry
   localparam int MAX_HEIGHT         = 4096;
   localparam int CFG_WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS        = 13;
   localparam int ROW_BITS           = 12;
   localparam int VROW_BITS          = 13;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // Register port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 13;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 4'd1;

   // Item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Payload field widths
   localparam int IN_CHANNEL_BITS = 16;
   localparam int EDGE_BITS       = 37;
   localparam int OUT_COL_BITS    = 10;
   localparam int OUT_ROW_BITS    = 12;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Neighbor order: left column top/mid/bottom, center top/bottom,
   // right column top/mid/bottom. Slot = window column, line = window row.
   localparam int NBR_COUNT = 8;
   localparam logic [1:0] NBR_SLOT [NBR_COUNT] =
      '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
   localparam logic [1:0] NBR_LINE [NBR_COUNT] =
      '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};

   typedef struct packed {
      logic                       kind;
      logic [IN_CHANNEL_BITS-1:0] red;
      logic [IN_CHANNEL_BITS-1:0] green;
      logic [IN_CHANNEL_BITS-1:0] blue;
   } ncde_req_type;

   typedef struct packed {
      logic [EDGE_BITS-1:0]    edge_strength;
      logic [OUT_COL_BITS-1:0] pixel_column;
      logic [OUT_ROW_BITS-1:0] pixel_row;
      logic                    frame_last;
   } ncde_rsp_type;

   // What the front decided about one item
   typedef struct packed {
      logic                    has_result;
      logic [NBR_COUNT-1:0]    nbr_mask;
      logic [OUT_COL_BITS-1:0] column;
      logic [OUT_ROW_BITS-1:0] row;
      logic                    last;
   } ncde_meta_type;

endpackage

// ===== rtl/core/ncde_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncde_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ncde_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ncde_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncde_queue
// Small FIFO that decouples the classifying front from the back pipeline.
// ----------------------------------------------------------------------------
module ncde_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4,
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 full,
   output logic                 not_empty
);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   // pointer wrap and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);

endmodule

// ===== rtl/core/ncde_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncde_front
// Accepts items, tracks the raster position and the drain, holds the frame
// registers and classifies each item for the back pipeline.
// ----------------------------------------------------------------------------
module ncde_front #(
   parameter int MAX_WIDTH    = ncde_pkg::MAX_WIDTH_DEFAULT,
   parameter int CHANNEL_BITS = ncde_pkg::CHANNEL_BITS_DEFAULT,
   localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // item channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  ncde_pkg::ncde_req_type                 req_data,
   // register port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ncde_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ncde_pkg::CSR_DATA_BITS-1:0]     csr_data,
   // command toward the queue
   input  logic                                   queue_full,
   output logic                                   cmd_push,
   output logic [COL_BITS-1:0]                    cmd_col,
   output logic [2:0][CHANNEL_BITS-1:0]           cmd_pix,
   output ncde_pkg::ncde_meta_type                cmd_meta
);

   import ncde_pkg::*;

   localparam int WBITS     = $clog2(MAX_WIDTH + 1);
   localparam int PEND_BITS = $clog2(MAX_WIDTH + 2);

   logic [CFG_WIDTH_BITS-1:0] cfg_width_ff;
   logic [HEIGHT_BITS-1:0]    cfg_height_ff;
   logic [WBITS-1:0]          w_eff;
   logic [HEIGHT_BITS-1:0]    h_eff;

   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [PEND_BITS-1:0] pend_ff, pend_in;

   logic                 csr_fire, accept, is_flush, drop, wrap;
   logic [PEND_BITS-1:0] drain_pos;
   logic [COL_BITS-1:0]  v_col;
   logic [VROW_BITS-1:0] v_row;
   logic [WBITS-1:0]     col_inc;
   logic [VROW_BITS-1:0] row_inc;
   logic                 pre, left_ok, right_ok, top_ok, bot_ok;
   logic [2:0]           slot_ok, line_ok;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // effective frame size, clamped
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WBITS'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = WBITS'(MAX_WIDTH);
      end else begin
         w_eff = WBITS'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = HEIGHT_BITS'(1);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         h_eff = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = cfg_height_ff;
      end
   end

   // virtual position of the item and next raster position
   always_comb begin
      is_flush  = (req_data.kind == KIND_FLUSH);
      drop      = is_flush && (pend_ff == '0);
      wrap      = (WBITS'(col_ff) >= w_eff) || (HEIGHT_BITS'(row_ff) >= h_eff);
      drain_pos = PEND_BITS'(w_eff) + PEND_BITS'(1) - pend_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;
      col_inc   = '0;
      row_inc   = '0;
      if (is_flush) begin
         // drain tick: an out-of-frame pixel past the last row
         if (drain_pos < PEND_BITS'(w_eff)) begin
            v_col = COL_BITS'(drain_pos);
            v_row = h_eff;
         end else begin
            v_col = '0;
            v_row = h_eff + VROW_BITS'(1);
         end
         if (!drop) begin
            pend_in = pend_ff - PEND_BITS'(1);
         end
      end else begin
         v_col   = wrap ? '0 : col_ff;
         v_row   = wrap ? '0 : VROW_BITS'(row_ff);
         pend_in = '0;
         col_inc = WBITS'(v_col) + WBITS'(1);
         row_inc = v_row + VROW_BITS'(1);
         if (col_inc >= w_eff) begin
            col_in = '0;
            if (row_inc >= h_eff) begin
               row_in  = '0;
               pend_in = PEND_BITS'(w_eff) + PEND_BITS'(1);
            end else begin
               row_in = ROW_BITS'(row_inc);
            end
         end else begin
            col_in = COL_BITS'(col_inc);
         end
      end
   end

   // classification: which centre is finished and which neighbors count.
   // At column zero the centre is the end of the row before last; otherwise
   // it is one column back on the previous row.
   always_comb begin
      pre = (v_col == '0);
      cmd_meta = '0;
      if (pre) begin
         cmd_meta.has_result = (v_row >= VROW_BITS'(2)) &&
                               ((v_row <= h_eff) || (v_row == h_eff + VROW_BITS'(1)));
         left_ok  = (w_eff >= WBITS'(2));
         right_ok = 1'b0;
         top_ok   = (v_row >= VROW_BITS'(3));
         bot_ok   = (v_row <= h_eff);
         cmd_meta.last   = (v_row == h_eff + VROW_BITS'(1));
         cmd_meta.column = OUT_COL_BITS'(w_eff - WBITS'(1));
         cmd_meta.row    = OUT_ROW_BITS'(v_row - VROW_BITS'(2));
      end else begin
         cmd_meta.has_result = (v_row >= VROW_BITS'(1)) && (v_row <= h_eff);
         left_ok  = (v_col >= COL_BITS'(2));
         right_ok = 1'b1;
         top_ok   = (v_row >= VROW_BITS'(2));
         bot_ok   = (v_row < h_eff);
         cmd_meta.last   = 1'b0;
         cmd_meta.column = OUT_COL_BITS'(v_col - COL_BITS'(1));
         cmd_meta.row    = OUT_ROW_BITS'(v_row - VROW_BITS'(1));
      end
      slot_ok = {right_ok, 1'b1, left_ok};
      line_ok = {bot_ok, 1'b1, top_ok};
      for (int n = 0; n < NBR_COUNT; n++) begin
         cmd_meta.nbr_mask[n] = slot_ok[NBR_SLOT[n]] && line_ok[NBR_LINE[n]];
      end
   end

   assign cmd_push   = accept && !drop;
   assign cmd_col    = v_col;
   assign cmd_pix[2] = is_flush ? '0 : CHANNEL_BITS'(req_data.red);
   assign cmd_pix[1] = is_flush ? '0 : CHANNEL_BITS'(req_data.green);
   assign cmd_pix[0] = is_flush ? '0 : CHANNEL_BITS'(req_data.blue);

   // registers and position state; a write to either frame register restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= CFG_WIDTH_BITS'(FRAME_WIDTH_RESET);
         cfg_height_ff <= HEIGHT_BITS'(FRAME_HEIGHT_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
         pend_ff       <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               cfg_width_ff <= csr_data[CFG_WIDTH_BITS-1:0];
               col_ff       <= '0;
               row_ff       <= '0;
               pend_ff      <= '0;
            end
            CSR_FRAME_HEIGHT: begin
               cfg_height_ff <= csr_data[HEIGHT_BITS-1:0];
               col_ff        <= '0;
               row_ff        <= '0;
               pend_ff       <= '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// ===== rtl/core/ncde_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncde_back
// Line buffers, 3x3 window and the squared-difference sum pipeline.
// ----------------------------------------------------------------------------
module ncde_back #(
   parameter int MAX_WIDTH    = ncde_pkg::MAX_WIDTH_DEFAULT,
   parameter int CHANNEL_BITS = ncde_pkg::CHANNEL_BITS_DEFAULT,
   localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   // command from the queue
   input  logic                         q_valid,
   input  logic [COL_BITS-1:0]          q_col,
   input  logic [2:0][CHANNEL_BITS-1:0] q_pix,
   input  ncde_pkg::ncde_meta_type      q_meta,
   output logic                         q_pop,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ncde_pkg::ncde_rsp_type       rsp_data
);

   import ncde_pkg::*;

   localparam int PIX_BITS  = 3 * CHANNEL_BITS;
   localparam int SQ_BITS   = 2 * CHANNEL_BITS;
   localparam int NBR_BITS  = SQ_BITS + 2;
   localparam int HALF_BITS = SQ_BITS + 4;
   localparam int SUM_BITS  = SQ_BITS + 5;

   typedef logic [2:0][CHANNEL_BITS-1:0] pixel_type;

   logic adv;

   // read stage
   logic          r_valid_ff;
   logic [COL_BITS-1:0] r_col_ff;
   pixel_type     r_pix_ff;
   ncde_meta_type r_meta_ff;
   logic          fwd_ff, fwd_in;
   pixel_type     fwd_above_ff, fwd_middle_ff;
   pixel_type     above_rd, middle_rd, above_eff, middle_eff;

   // window stage
   pixel_type     win_ff [3][3];
   logic          w_valid_ff;
   ncde_meta_type w_meta_ff;

   // arithmetic stages
   logic                    d_valid_ff, s_valid_ff, p_valid_ff, h_valid_ff;
   ncde_meta_type           d_meta_ff, s_meta_ff, p_meta_ff, h_meta_ff;
   logic [CHANNEL_BITS-1:0] d_diff_in [NBR_COUNT][3];
   logic [CHANNEL_BITS-1:0] d_diff_ff [NBR_COUNT][3];
   logic [SQ_BITS-1:0]      s_sq_ff [NBR_COUNT][3];
   logic [NBR_BITS-1:0]     p_nbr_ff [NBR_COUNT];
   logic [HALF_BITS-1:0]    h_half_ff [2];
   logic [SUM_BITS-1:0]     total_in;

   logic         rsp_valid_ff;
   ncde_rsp_type rsp_data_ff;

   // the whole back pipeline moves together unless the output is held
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // line buffers: above holds row-2, middle holds row-1 for each column
   ncde_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_above_ram (
      .clock   (clock),
      .wr_en   (adv && r_valid_ff),
      .wr_addr (r_col_ff),
      .wr_data (middle_eff),
      .rd_en   (adv),
      .rd_addr (q_col),
      .rd_data (above_rd)
   );

   ncde_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock   (clock),
      .wr_en   (adv && r_valid_ff),
      .wr_addr (r_col_ff),
      .wr_data (r_pix_ff),
      .rd_en   (adv),
      .rd_addr (q_col),
      .rd_data (middle_rd)
   );

   // a read of the column being written in the same cycle takes the new words
   assign fwd_in     = adv && r_valid_ff && q_valid && (q_col == r_col_ff);
   assign above_eff  = fwd_ff ? fwd_above_ff : above_rd;
   assign middle_eff = fwd_ff ? fwd_middle_ff : middle_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else if (adv) begin
         r_valid_ff <= q_valid;
         fwd_ff     <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_col_ff      <= q_col;
         r_pix_ff      <= q_pix;
         r_meta_ff     <= q_meta;
         fwd_above_ff  <= middle_eff;
         fwd_middle_ff <= r_pix_ff;
      end
   end

   // window shift: column slots move left, new column enters at slot 2
   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         for (int s = 0; s < 3; s++) begin
            for (int l = 0; l < 3; l++) begin
               win_ff[s][l] <= '0;
            end
         end
      end else if (adv) begin
         w_valid_ff <= r_valid_ff;
         if (r_valid_ff) begin
            win_ff[0]    <= win_ff[1];
            win_ff[1]    <= win_ff[2];
            win_ff[2][0] <= above_eff;
            win_ff[2][1] <= middle_eff;
            win_ff[2][2] <= r_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_meta_ff <= r_meta_ff;
      end
   end

   // absolute channel differences to the centre
   always_comb begin
      for (int n = 0; n < NBR_COUNT; n++) begin
         for (int c = 0; c < 3; c++) begin
            if (win_ff[1][1][c] > win_ff[NBR_SLOT[n]][NBR_LINE[n]][c]) begin
               d_diff_in[n][c] = win_ff[1][1][c] - win_ff[NBR_SLOT[n]][NBR_LINE[n]][c];
            end else begin
               d_diff_in[n][c] = win_ff[NBR_SLOT[n]][NBR_LINE[n]][c] - win_ff[1][1][c];
            end
         end
      end
   end

   assign total_in = SUM_BITS'(h_half_ff[0]) + SUM_BITS'(h_half_ff[1]);

   // valid chain of the arithmetic pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff   <= w_valid_ff && w_meta_ff.has_result;
         s_valid_ff   <= d_valid_ff;
         p_valid_ff   <= s_valid_ff;
         h_valid_ff   <= p_valid_ff;
         rsp_valid_ff <= h_valid_ff;
      end
   end

   // diff -> square -> masked neighbor sum -> half sums -> total
   always_ff @(posedge clock) begin
      if (adv) begin
         d_meta_ff <= w_meta_ff;
         s_meta_ff <= d_meta_ff;
         p_meta_ff <= s_meta_ff;
         h_meta_ff <= p_meta_ff;
         for (int n = 0; n < NBR_COUNT; n++) begin
            for (int c = 0; c < 3; c++) begin
               d_diff_ff[n][c] <= d_diff_in[n][c];
               s_sq_ff[n][c]   <= SQ_BITS'(d_diff_ff[n][c]) * SQ_BITS'(d_diff_ff[n][c]);
            end
            if (s_meta_ff.nbr_mask[n]) begin
               p_nbr_ff[n] <= NBR_BITS'(s_sq_ff[n][0]) + NBR_BITS'(s_sq_ff[n][1]) +
                              NBR_BITS'(s_sq_ff[n][2]);
            end else begin
               p_nbr_ff[n] <= '0;
            end
         end
         h_half_ff[0] <= HALF_BITS'(p_nbr_ff[0]) + HALF_BITS'(p_nbr_ff[1]) +
                         HALF_BITS'(p_nbr_ff[2]) + HALF_BITS'(p_nbr_ff[3]);
         h_half_ff[1] <= HALF_BITS'(p_nbr_ff[4]) + HALF_BITS'(p_nbr_ff[5]) +
                         HALF_BITS'(p_nbr_ff[6]) + HALF_BITS'(p_nbr_ff[7]);
         rsp_data_ff.edge_strength <= EDGE_BITS'(total_in);
         rsp_data_ff.pixel_column  <= h_meta_ff.column;
         rsp_data_ff.pixel_row     <= h_meta_ff.row;
         rsp_data_ff.frame_last    <= h_meta_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/neighbour_color_difference_edge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_color_difference_edge_core
// 3x3 sum of squared RGB differences over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : items in raster order, kind = pixel or flush tick. A transaction
//            completes when req_valid is high and req_stall is low.
//   rsp_*  : at most one result per item: edge strength (Q37.0), centre
//            column/row and a frame_last flag on the final pixel of a frame.
//   csr_*  : index 0 = frame width, index 1 = frame height; csr_ready is
//            always high. A write restarts the frame; write only when idle.
// Throughput: one item per clock while req_stall is low; the queue and back
//   pipeline both run at one transaction a cycle unless rsp_stall holds the
//   output; line-buffer RAMs take one read and one write per cycle.
// Window: a result is issued for the item that completes its window, which
//   is frame_width + 1 items after its centre pixel. After the last pixel,
//   frame_width + 1 flush ticks drain the final row.
// Reset: synchronous; clears position, drain count, queue and pipeline
//   valids and restores the frame registers to 640 x 480. Line buffers are
//   not cleared; entries are always written before they matter.
// Stall: rsp_stall freezes the whole back pipeline; the queue keeps taking
//   items until it is full, then req_stall rises.
// ----------------------------------------------------------------------------
module neighbour_color_difference_edge_core #(
   parameter int MAX_WIDTH    = ncde_pkg::MAX_WIDTH_DEFAULT,
   parameter int CHANNEL_BITS = ncde_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ncde_pkg::ncde_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ncde_pkg::ncde_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ncde_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ncde_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import ncde_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int DATA_BITS = COL_BITS + 3 * CHANNEL_BITS + $bits(ncde_meta_type);

   logic                         queue_full, queue_not_empty, queue_pop, cmd_push;
   logic [COL_BITS-1:0]          cmd_col, q_col;
   logic [2:0][CHANNEL_BITS-1:0] cmd_pix, q_pix;
   ncde_meta_type                cmd_meta, q_meta;
   logic [DATA_BITS-1:0]         q_data;

   // front: accept and classify
   ncde_front #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd_col    (cmd_col),
      .cmd_pix    (cmd_pix),
      .cmd_meta   (cmd_meta)
   );

   // command queue
   ncde_queue #(.DATA_BITS(DATA_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({cmd_col, cmd_pix, cmd_meta}),
      .pop       (queue_pop),
      .pop_data  (q_data),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   assign {q_col, q_pix, q_meta} = q_data;

   // back: line buffers, window and arithmetic
   ncde_back #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (queue_not_empty),
      .q_col     (q_col),
      .q_pix     (q_pix),
      .q_meta    (q_meta),
      .q_pop     (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/ncde_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncde_checker
// Port-level checks of the edge core, attached by bind.
// ----------------------------------------------------------------------------
module ncde_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input ncde_pkg::ncde_rsp_type              rsp_data,
   input logic                                csr_valid
);

   // a held result keeps its payload
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result changed while stalled");

   // reset empties the back pipeline
   property p_reset_no_rsp;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_no_rsp: assert property (p_reset_no_rsp)
      else $error("result valid right after reset");

   // reset empties the queue, so items are taken at once
   property p_reset_no_stall;
      @(posedge clock) reset |=> !req_stall;
   endproperty
   a_reset_no_stall: assert property (p_reset_no_stall)
      else $error("input stalled right after reset");

   // a stalled result is not dropped while no item or register write is offered
   property p_rsp_kept;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall && !req_valid && !csr_valid |=> rsp_valid;
   endproperty
   a_rsp_kept: assert property (p_rsp_kept)
      else $error("stalled result lost");

endmodule

bind neighbour_color_difference_edge_core ncde_checker u_ncde_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid)
);
